// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MKTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MKTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mkte_pkg.sv -----
// types, constants and helper functions of the keypad text entry block
package mkte_pkg;

    localparam int MASK_W     = 9;
    localparam int KEY_W      = 4;
    localparam int CNT_W      = 4;
    localparam int STEP_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 5;
    localparam int PRESS_W    = 14;
    localparam int CURSOR_W   = 6;
    localparam int SLOT_EXT_W = 7;

    localparam logic [PRESS_W-1:0]  PRESS_MAX  = 14'd9999;
    localparam logic [CURSOR_W-1:0] CURSOR_MAX = 6'd63;
    localparam logic [STEP_W-1:0]   STEP_LAST  = 2'd2;

    localparam logic [MASK_W-1:0] CHORD_CLEAR = 9'h006;
    localparam logic [MASK_W-1:0] CHORD_MODE  = 9'h030;
    localparam logic [MASK_W-1:0] CHORD_SPACE = 9'h180;

    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_DIGIT,
        KIND_LETTER,
        KIND_CLEAR,
        KIND_TOGGLE,
        KIND_SPACE,
        KIND_PAIR
    } t_kind;

    typedef enum logic [2:0] {
        ED_NONE,
        ED_CLEAR,
        ED_DIGIT,
        ED_LETTER,
        ED_TOGGLE,
        ED_SPACE,
        ED_SHIFT,
        ED_SHIFT_END
    } t_edit;

    typedef enum logic [1:0] {
        RD_CURSOR,
        RD_IDX,
        RD_IDX_P1,
        RD_IDX_P2
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHORD,
        S_CHECK,
        S_TEST,
        S_SHIFT,
        S_SHIFT_END,
        S_EMIT_PRE,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    take_mask;
        logic    count_press;
        t_edit   edit;
        t_rd_sel rd_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  scroll;
        logic  idx_last;
        logic  out_free;
    } t_stat;

    function automatic logic [CHAR_W-1:0] letter_code(input logic [KEY_W-1:0]  key,
                                                      input logic [STEP_W-1:0] step);
        logic [3*CHAR_W-1:0] letters;
        logic [CHAR_W-1:0]   code;
        case (key)
            4'd1:    letters = ".QZ";
            4'd2:    letters = "ABC";
            4'd3:    letters = "DEF";
            4'd4:    letters = "GHI";
            4'd5:    letters = "JKL";
            4'd6:    letters = "MNO";
            4'd7:    letters = "PRS";
            4'd8:    letters = "TUV";
            4'd9:    letters = "WXY";
            default: letters = '0;
        endcase
        case (step)
            2'd0:    code = letters[3*CHAR_W-1:2*CHAR_W];
            2'd1:    code = letters[2*CHAR_W-1:CHAR_W];
            2'd2:    code = letters[CHAR_W-1:0];
            default: code = '0;
        endcase
        return code;
    endfunction

    function automatic logic [CURSOR_W-1:0] cursor_inc(input logic [CURSOR_W-1:0] c);
        return (c == CURSOR_MAX) ? CURSOR_MAX : c + 6'd1;
    endfunction

endpackage

// ----- hdl/mkte_dpath.sv -----
// datapath: text memory, cursor and entry state, press counter, output register
module mkte_dpath #(
    parameter int VISIBLE_CHARS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mkte_pkg::t_cmd                      i_cmd,
    output mkte_pkg::t_stat                     o_stat,
    input  logic [mkte_pkg::MASK_W-1:0]         i_switch_mask,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [mkte_pkg::POS_W-1:0]          o_char_position,
    output logic [mkte_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                o_letters_mode,
    output logic [mkte_pkg::PRESS_W-1:0]        o_press_total,
    output logic [mkte_pkg::CURSOR_W-1:0]       o_write_position,
    output logic                                o_last_of_run
);

    localparam int SLOTS = VISIBLE_CHARS + 2;
    localparam int AW    = $clog2(SLOTS);
    localparam int IDX_W = $clog2(VISIBLE_CHARS);
    localparam logic [mkte_pkg::SLOT_EXT_W-1:0] VIS_EXT   = mkte_pkg::SLOT_EXT_W'(VISIBLE_CHARS);
    localparam logic [mkte_pkg::SLOT_EXT_W-1:0] SLOTS_EXT = mkte_pkg::SLOT_EXT_W'(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VISIBLE_CHARS - 1);
    localparam logic [AW-1:0]    TOP_IDX  = AW'(VISIBLE_CHARS);

    logic [mkte_pkg::MASK_W-1:0]     r_mask;
    logic [mkte_pkg::CURSOR_W-1:0]   r_cursor, n_cursor;
    logic [mkte_pkg::KEY_W-1:0]      r_prev_key, n_prev_key;
    logic [mkte_pkg::STEP_W-1:0]     r_step, n_step;
    logic                            r_letters, n_letters;
    logic [mkte_pkg::PRESS_W-1:0]    r_press, n_press;
    logic [IDX_W-1:0]                r_idx;
    logic [SLOTS-1:0]                r_slot_ok;
    logic [mkte_pkg::CHAR_W-1:0]     r_mem [SLOTS];
    logic [mkte_pkg::CHAR_W-1:0]     r_rd_data;
    logic                            r_rd_ok;

    logic                            r_out_valid;
    logic [mkte_pkg::POS_W-1:0]      r_out_pos;
    logic [mkte_pkg::CHAR_W-1:0]     r_out_code;
    logic                            r_out_mode;
    logic [mkte_pkg::PRESS_W-1:0]    r_out_press;
    logic [mkte_pkg::CURSOR_W-1:0]   r_out_wpos;
    logic                            r_out_last;

    logic [mkte_pkg::CNT_W-1:0]      key_cnt;
    logic [mkte_pkg::KEY_W-1:0]      key;
    mkte_pkg::t_kind                 kind;
    logic [mkte_pkg::PRESS_W:0]      press_sum;

    logic [mkte_pkg::SLOT_EXT_W-1:0] cur_ext, idx_ext, rd_addr, wr_addr;
    logic                            rd_in, wr_en, wr_ok, clr_all, clr_top;
    logic [mkte_pkg::CHAR_W-1:0]     wr_data, rd_val;
    logic                            occupied;
    logic                            adv;
    logic [mkte_pkg::CURSOR_W-1:0]   c1;
    logic [mkte_pkg::STEP_W-1:0]     s1;

    // key decode from the latched scan
    always_comb begin
        key_cnt = '0;
        key     = '0;
        for (int k = mkte_pkg::MASK_W - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                key     = mkte_pkg::KEY_W'(k + 1);
                key_cnt = key_cnt + 4'd1;
            end
        end
    end

    always_comb begin
        case (key_cnt)
            4'd1: begin
                kind = r_letters ? mkte_pkg::KIND_LETTER : mkte_pkg::KIND_DIGIT;
            end
            4'd2: begin
                if (r_mask == mkte_pkg::CHORD_CLEAR) begin
                    kind = mkte_pkg::KIND_CLEAR;
                end else if (r_mask == mkte_pkg::CHORD_MODE) begin
                    kind = mkte_pkg::KIND_TOGGLE;
                end else if (r_mask == mkte_pkg::CHORD_SPACE) begin
                    kind = mkte_pkg::KIND_SPACE;
                end else begin
                    kind = mkte_pkg::KIND_PAIR;
                end
            end
            default: kind = mkte_pkg::KIND_NONE;
        endcase
    end

    assign press_sum = {1'b0, r_press} + (mkte_pkg::PRESS_W + 1)'(key_cnt);

    always_comb begin
        if (press_sum > {1'b0, mkte_pkg::PRESS_MAX}) begin
            n_press = mkte_pkg::PRESS_MAX;
        end else begin
            n_press = press_sum[mkte_pkg::PRESS_W-1:0];
        end
    end

    assign cur_ext  = mkte_pkg::SLOT_EXT_W'(r_cursor);
    assign idx_ext  = mkte_pkg::SLOT_EXT_W'(r_idx);
    assign rd_val   = r_rd_ok ? r_rd_data : '0;
    assign occupied = |rd_val;

    always_comb begin
        case (i_cmd.rd_sel)
            mkte_pkg::RD_CURSOR: rd_addr = cur_ext;
            mkte_pkg::RD_IDX:    rd_addr = idx_ext;
            mkte_pkg::RD_IDX_P1: rd_addr = idx_ext + mkte_pkg::SLOT_EXT_W'(1);
            mkte_pkg::RD_IDX_P2: rd_addr = idx_ext + mkte_pkg::SLOT_EXT_W'(2);
            default:             rd_addr = cur_ext;
        endcase
    end

    assign rd_in = rd_addr < SLOTS_EXT;

    // edit of the entry state and the single write into the text memory
    always_comb begin
        n_cursor   = r_cursor;
        n_prev_key = r_prev_key;
        n_step     = r_step;
        n_letters  = r_letters;
        wr_en      = 1'b0;
        wr_addr    = cur_ext;
        wr_data    = '0;
        clr_all    = 1'b0;
        clr_top    = 1'b0;
        adv        = (r_prev_key != key) && (r_prev_key != '0);
        c1         = adv ? mkte_pkg::cursor_inc(r_cursor) : r_cursor;
        s1         = (adv || r_step > mkte_pkg::STEP_LAST) ? '0 : r_step;
        case (i_cmd.edit)
            mkte_pkg::ED_CLEAR: begin
                clr_all    = 1'b1;
                n_cursor   = '0;
                n_prev_key = '0;
                n_step     = '0;
            end
            mkte_pkg::ED_DIGIT: begin
                wr_en    = 1'b1;
                wr_data  = mkte_pkg::CODE_ZERO + mkte_pkg::CHAR_W'(key);
                n_cursor = mkte_pkg::cursor_inc(r_cursor);
            end
            mkte_pkg::ED_LETTER: begin
                wr_en      = 1'b1;
                wr_addr    = mkte_pkg::SLOT_EXT_W'(c1);
                wr_data    = mkte_pkg::letter_code(key, s1);
                n_cursor   = c1;
                n_step     = (s1 == mkte_pkg::STEP_LAST) ? '0 : s1 + 2'd1;
                n_prev_key = key;
            end
            mkte_pkg::ED_TOGGLE: begin
                if (occupied) begin
                    n_cursor   = mkte_pkg::cursor_inc(r_cursor);
                    n_prev_key = '0;
                    n_step     = '0;
                end
                n_letters = ~r_letters;
            end
            mkte_pkg::ED_SPACE: begin
                // step off an occupied slot before writing the space
                wr_en      = 1'b1;
                wr_addr    = occupied ? mkte_pkg::SLOT_EXT_W'(mkte_pkg::cursor_inc(r_cursor))
                                      : cur_ext;
                wr_data    = mkte_pkg::CODE_SPACE;
                n_cursor   = occupied ? mkte_pkg::cursor_inc(mkte_pkg::cursor_inc(r_cursor))
                                      : mkte_pkg::cursor_inc(r_cursor);
                n_prev_key = '0;
                n_step     = '0;
            end
            mkte_pkg::ED_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = idx_ext;
                wr_data = rd_val;
            end
            mkte_pkg::ED_SHIFT_END: begin
                clr_top  = 1'b1;
                n_cursor = r_cursor - 6'd1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign wr_ok = wr_en && (wr_addr < SLOTS_EXT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_prev_key <= '0;
            r_step     <= '0;
            r_letters  <= 1'b1;
            r_press    <= '0;
            r_idx      <= '0;
        end else begin
            r_cursor   <= n_cursor;
            r_prev_key <= n_prev_key;
            r_step     <= n_step;
            r_letters  <= n_letters;
            if (i_cmd.count_press) begin
                r_press <= n_press;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_mask) begin
            r_mask <= i_switch_mask;
        end
    end

    // per-slot written flags, an unwritten slot reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ok <= '0;
        end else if (clr_all) begin
            r_slot_ok <= '0;
        end else begin
            if (wr_ok) begin
                r_slot_ok[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (clr_top) begin
                r_slot_ok[TOP_IDX] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_in) begin
            r_rd_data <= r_mem[rd_addr[AW-1:0]];
        end
        r_rd_ok <= rd_in && r_slot_ok[rd_addr[AW-1:0]];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pos   <= idx_ext[mkte_pkg::POS_W-1:0];
            r_out_code  <= rd_val;
            r_out_mode  <= r_letters;
            r_out_press <= r_press;
            r_out_wpos  <= r_cursor;
            r_out_last  <= (r_idx == IDX_LAST);
        end
    end

    always_comb begin
        o_stat.kind     = kind;
        o_stat.scroll   = (cur_ext >= VIS_EXT) && !((cur_ext == VIS_EXT) && !occupied);
        o_stat.idx_last = (r_idx == IDX_LAST);
        o_stat.out_free = !r_out_valid || i_ready;
    end

    assign o_valid          = r_out_valid;
    assign o_char_position  = r_out_pos;
    assign o_char_code      = r_out_code;
    assign o_letters_mode   = r_out_mode;
    assign o_press_total    = r_out_press;
    assign o_write_position = r_out_wpos;
    assign o_last_of_run    = r_out_last;

endmodule

// ----- hdl/mkte_ctrl.sv -----
// controller: sequences decode, edit, scroll sweep and character output of one scan
module mkte_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mkte_pkg::t_stat  i_stat,
    output mkte_pkg::t_cmd   o_cmd
);

    mkte_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mkte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mkte_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = mkte_pkg::S_DECODE;
                end
            end
            mkte_pkg::S_DECODE: begin
                case (i_stat.kind)
                    mkte_pkg::KIND_DIGIT:  n_state = mkte_pkg::S_CHECK;
                    mkte_pkg::KIND_LETTER: n_state = mkte_pkg::S_CHECK;
                    mkte_pkg::KIND_PAIR:   n_state = mkte_pkg::S_CHECK;
                    mkte_pkg::KIND_TOGGLE: n_state = mkte_pkg::S_CHORD;
                    mkte_pkg::KIND_SPACE:  n_state = mkte_pkg::S_CHORD;
                    default:               n_state = mkte_pkg::S_EMIT_PRE;
                endcase
            end
            mkte_pkg::S_CHORD: begin
                if (i_stat.kind == mkte_pkg::KIND_TOGGLE) begin
                    n_state = mkte_pkg::S_EMIT_PRE;
                end else begin
                    n_state = mkte_pkg::S_CHECK;
                end
            end
            mkte_pkg::S_CHECK: n_state = mkte_pkg::S_TEST;
            mkte_pkg::S_TEST: begin
                n_state = i_stat.scroll ? mkte_pkg::S_SHIFT : mkte_pkg::S_EMIT_PRE;
            end
            mkte_pkg::S_SHIFT: begin
                if (i_stat.idx_last) begin
                    n_state = mkte_pkg::S_SHIFT_END;
                end
            end
            mkte_pkg::S_SHIFT_END: n_state = mkte_pkg::S_EMIT_PRE;
            mkte_pkg::S_EMIT_PRE:  n_state = mkte_pkg::S_EMIT_RD;
            mkte_pkg::S_EMIT_RD:   n_state = mkte_pkg::S_EMIT;
            mkte_pkg::S_EMIT: begin
                if (i_stat.out_free && i_stat.idx_last) begin
                    n_state = mkte_pkg::S_IDLE;
                end
            end
            default: n_state = mkte_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready           = 1'b0;
        o_cmd.take_mask   = 1'b0;
        o_cmd.count_press = 1'b0;
        o_cmd.edit        = mkte_pkg::ED_NONE;
        o_cmd.rd_sel      = mkte_pkg::RD_CURSOR;
        o_cmd.idx_clr     = 1'b0;
        o_cmd.idx_inc     = 1'b0;
        o_cmd.out_load    = 1'b0;
        case (r_state)
            mkte_pkg::S_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.take_mask = i_valid;
            end
            mkte_pkg::S_DECODE: begin
                o_cmd.count_press = 1'b1;
                case (i_stat.kind)
                    mkte_pkg::KIND_DIGIT:  o_cmd.edit = mkte_pkg::ED_DIGIT;
                    mkte_pkg::KIND_LETTER: o_cmd.edit = mkte_pkg::ED_LETTER;
                    mkte_pkg::KIND_CLEAR:  o_cmd.edit = mkte_pkg::ED_CLEAR;
                    default:               o_cmd.edit = mkte_pkg::ED_NONE;
                endcase
            end
            mkte_pkg::S_CHORD: begin
                if (i_stat.kind == mkte_pkg::KIND_TOGGLE) begin
                    o_cmd.edit = mkte_pkg::ED_TOGGLE;
                end else begin
                    o_cmd.edit = mkte_pkg::ED_SPACE;
                end
            end
            mkte_pkg::S_CHECK: begin
                o_cmd.idx_clr = 1'b1;
            end
            mkte_pkg::S_TEST: begin
                o_cmd.rd_sel = mkte_pkg::RD_IDX_P1;
            end
            mkte_pkg::S_SHIFT: begin
                // write slot idx with slot idx+1 while fetching slot idx+2
                o_cmd.edit    = mkte_pkg::ED_SHIFT;
                o_cmd.rd_sel  = mkte_pkg::RD_IDX_P2;
                o_cmd.idx_inc = 1'b1;
            end
            mkte_pkg::S_SHIFT_END: begin
                o_cmd.edit = mkte_pkg::ED_SHIFT_END;
            end
            mkte_pkg::S_EMIT_PRE: begin
                o_cmd.idx_clr = 1'b1;
            end
            mkte_pkg::S_EMIT_RD: begin
                o_cmd.rd_sel = mkte_pkg::RD_IDX;
            end
            mkte_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                    o_cmd.rd_sel   = mkte_pkg::RD_IDX_P1;
                end else begin
                    o_cmd.rd_sel = mkte_pkg::RD_IDX;
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/multitap_keypad_text_entry.sv -----
// Multi-tap keypad text entry. Each item is one scan of a nine-key mask; the block
// edits a text memory of VISIBLE_CHARS+2 slots and then emits VISIBLE_CHARS result
// items, one per visible character in order, the last flagged by o_last_of_run.
// One scan at a time. The spacing of accepted scans depends on the kind of scan (no key,
// a clear or three or more keys; a mode toggle; a single key or a plain key pair; a space)
// and grows when the output side stalls; a scan that scrolls adds a copy sweep, one slot
// per cycle through the single memory write port. The next scan is accepted once the
// final character sits in the output register. Reset clears the text memory at once
// through per-slot flags.
module multitap_keypad_text_entry #(
    parameter int VISIBLE_CHARS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [mkte_pkg::MASK_W-1:0]         i_switch_mask,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mkte_pkg::POS_W-1:0]          o_char_position,
    output logic [mkte_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                o_letters_mode,
    output logic [mkte_pkg::PRESS_W-1:0]        o_press_total,
    output logic [mkte_pkg::CURSOR_W-1:0]       o_write_position,
    output logic                                o_last_of_run
);

    mkte_pkg::t_cmd  cmd;
    mkte_pkg::t_stat stat;

    mkte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mkte_dpath #(
        .VISIBLE_CHARS (VISIBLE_CHARS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_switch_mask    (i_switch_mask),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_char_position  (o_char_position),
        .o_char_code      (o_char_code),
        .o_letters_mode   (o_letters_mode),
        .o_press_total    (o_press_total),
        .o_write_position (o_write_position),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

// ----- hdl/mkte_checker.sv -----
// port-level checker for the keypad text entry block, bound to the top level
`include "assert_macros.svh"

module mkte_checker #(
    parameter int VISIBLE_CHARS = 32
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [mkte_pkg::POS_W-1:0]          o_char_position,
    input logic [mkte_pkg::CHAR_W-1:0]         o_char_code,
    input logic                                o_letters_mode,
    input logic [mkte_pkg::PRESS_W-1:0]        o_press_total,
    input logic [mkte_pkg::CURSOR_W-1:0]       o_write_position,
    input logic                                o_last_of_run
);

    localparam logic [mkte_pkg::POS_W-1:0] LAST_POS = mkte_pkg::POS_W'(VISIBLE_CHARS - 1);

    // the run flag sits on the final visible slot only
    `MKTE_ASSERT(a_last_pos, i_clk, i_rst_n, o_valid && o_last_of_run |-> o_char_position == LAST_POS, "last_of_run on wrong position")

    `MKTE_ASSERT(a_press_cap, i_clk, i_rst_n, o_valid |-> o_press_total <= mkte_pkg::PRESS_MAX, "press total above limit")

    // within a run positions count up and the letters mode and write position stay put
    `MKTE_ASSERT(a_run_order, i_clk, i_rst_n, o_valid && i_ready && !o_last_of_run |=> !o_valid || (o_char_position == $past(o_char_position) + 5'd1 && o_letters_mode == $past(o_letters_mode) && o_write_position == $past(o_write_position)), "run out of order")

    `MKTE_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_char_code) && $stable(o_char_position), "stalled item changed")

    `MKTE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind multitap_keypad_text_entry mkte_checker #(
    .VISIBLE_CHARS (VISIBLE_CHARS)
) u_mkte_checker (.*);
